// ----- hw/rtl/lifd_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, opcodes and state encoding for the fractional delay line
// no dependencies; used by lifd_cfg, lifd_pos, lifd_alu and the top level
package lifd_pkg;

    // line depth must be a power of two so that cell addresses wrap by truncation
    localparam int LINE_DEPTH_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int WHOLE_BITS    = 10;
    localparam int OPCODE_BITS   = 2;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_INDEX_LSB = 2;

    localparam logic [1:0] REG_DELAY_WHOLE    = 2'd0;
    localparam logic [1:0] REG_DELAY_FRACTION = 2'd1;
    localparam logic [1:0] REG_REVERSE_TAPS   = 2'd2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_TICK     = 2'd0,
        OP_TAP_READ = 2'd1,
        OP_TAP_ADD  = 2'd2,
        OP_TAP_SET  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

// ----- hw/rtl/lifd_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read memory with registered read data
// no dependencies
module lifd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lifd_cfg.sv -----
`timescale 1ns / 1ps
// apb register block: main delay whole and fraction, reverse tap mode
// depends on lifd_pkg
module lifd_cfg #(
    parameter int FRACTION_BITS = lifd_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lifd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lifd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [lifd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output logic [lifd_pkg::WHOLE_BITS-1:0]    delay_whole,
    output logic [FRACTION_BITS-1:0]           delay_fraction,
    output logic                               reverse_taps
);

    logic [lifd_pkg::WHOLE_BITS-1:0] delay_whole_reg;
    logic [FRACTION_BITS-1:0]        delay_fraction_reg;
    logic                            reverse_taps_reg;
    logic [1:0]                      reg_index;
    logic                            wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[lifd_pkg::APB_ADDR_BITS-1:lifd_pkg::REG_INDEX_LSB];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_whole_reg    <= '0;
            delay_fraction_reg <= '0;
            reverse_taps_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                lifd_pkg::REG_DELAY_WHOLE:
                begin
                    delay_whole_reg <= pwdata[lifd_pkg::WHOLE_BITS-1:0];
                end
                lifd_pkg::REG_DELAY_FRACTION:
                begin
                    delay_fraction_reg <= pwdata[FRACTION_BITS-1:0];
                end
                lifd_pkg::REG_REVERSE_TAPS:
                begin
                    reverse_taps_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            lifd_pkg::REG_DELAY_WHOLE:
            begin
                prdata = lifd_pkg::APB_DATA_BITS'(delay_whole_reg);
            end
            lifd_pkg::REG_DELAY_FRACTION:
            begin
                prdata = lifd_pkg::APB_DATA_BITS'(delay_fraction_reg);
            end
            lifd_pkg::REG_REVERSE_TAPS:
            begin
                prdata = lifd_pkg::APB_DATA_BITS'(reverse_taps_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign delay_whole    = delay_whole_reg;
    assign delay_fraction = delay_fraction_reg;
    assign reverse_taps   = reverse_taps_reg;

endmodule

// ----- hw/rtl/lifd_pos.sv -----
`timescale 1ns / 1ps
// position unit: tap clamp, reverse mirror, main delay select for ticks
// depends on lifd_pkg
module lifd_pos #(
    parameter int FRACTION_BITS = lifd_pkg::FRACTION_BITS_DEF
) (
    input  lifd_pkg::op_t                   op,
    input  logic [lifd_pkg::WHOLE_BITS-1:0] tap_whole,
    input  logic [FRACTION_BITS-1:0]        tap_fraction,
    input  logic [lifd_pkg::WHOLE_BITS-1:0] delay_whole,
    input  logic [FRACTION_BITS-1:0]        delay_fraction,
    input  logic                            reverse_taps,
    output logic [lifd_pkg::WHOLE_BITS-1:0] pos_whole,
    output logic [FRACTION_BITS-1:0]        pos_fraction
);

    localparam int PW = lifd_pkg::WHOLE_BITS + FRACTION_BITS;
    localparam logic [PW+1:0] POS_ONE = {{(PW+1){1'b0}}, 1'b1} << FRACTION_BITS;

    logic [PW-1:0]        tap_pos;
    logic [PW-1:0]        limit;
    logic [PW-1:0]        clamped;
    logic [PW-1:0]        picked;
    logic signed [PW+1:0] mirrored;

    assign tap_pos = {tap_whole, tap_fraction};
    assign limit   = {delay_whole, {FRACTION_BITS{1'b0}}};

    // tap reads never reach past the main delay
    assign clamped = (op == lifd_pkg::OP_TAP_READ && tap_pos >= limit) ? limit : tap_pos;

    // mirrored position: whole part of the main delay minus one minus position
    assign mirrored = $signed({2'b00, limit}) - $signed(POS_ONE) - $signed({2'b00, clamped});

    always_comb
    begin
        if (op == lifd_pkg::OP_TICK)
        begin
            picked = {delay_whole, delay_fraction};
        end
        else if (reverse_taps)
        begin
            picked = mirrored[PW+1] ? '0 : mirrored[PW-1:0];
        end
        else
        begin
            picked = clamped;
        end
    end

    assign pos_whole    = picked[PW-1:FRACTION_BITS];
    assign pos_fraction = picked[FRACTION_BITS-1:0];

endmodule

// ----- hw/rtl/lifd_alu.sv -----
`timescale 1ns / 1ps
// write-stage arithmetic: linear interpolation and saturating tap update
// depends on lifd_pkg
module lifd_alu #(
    parameter int SAMPLE_BITS   = lifd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lifd_pkg::FRACTION_BITS_DEF
) (
    input  lifd_pkg::op_t            op,
    input  logic [SAMPLE_BITS-1:0]   cell_a,
    input  logic [SAMPLE_BITS-1:0]   cell_b,
    input  logic [FRACTION_BITS-1:0] fraction,
    input  logic [SAMPLE_BITS-1:0]   part_a,
    input  logic [SAMPLE_BITS-1:0]   part_b,
    output logic [SAMPLE_BITS-1:0]   interp,
    output logic [SAMPLE_BITS-1:0]   new_a,
    output logic [SAMPLE_BITS-1:0]   new_b
);

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;

    logic signed [SB:0]      diff;
    logic signed [SB+FB+1:0] scaled;
    logic signed [SB+1:0]    step;
    logic signed [SB+1:0]    interp_sum;
    logic signed [SB:0]      base_a;
    logic signed [SB:0]      base_b;
    logic signed [SB:0]      sum_a;
    logic signed [SB:0]      sum_b;
    logic                    accumulate;

    function automatic logic [SB-1:0] saturate(input logic signed [SB:0] v);
        logic [SB-1:0] result;
        if (v[SB] != v[SB-1])
        begin
            result = v[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        else
        begin
            result = v[SB-1:0];
        end
        return result;
    endfunction

    // a + floor((b - a) * f), always between a and b
    assign diff       = $signed({cell_b[SB-1], cell_b}) - $signed({cell_a[SB-1], cell_a});
    assign scaled     = diff * $signed({1'b0, fraction});
    assign step       = scaled[SB+FB+1:FB];
    assign interp_sum = $signed({{2{cell_a[SB-1]}}, cell_a}) + step;
    assign interp     = interp_sum[SB-1:0];

    assign accumulate = (op == lifd_pkg::OP_TAP_ADD);
    assign base_a     = accumulate ? $signed({cell_a[SB-1], cell_a}) : '0;
    assign base_b     = accumulate ? $signed({cell_b[SB-1], cell_b}) : '0;
    assign sum_a      = base_a + $signed({part_a[SB-1], part_a});
    assign sum_b      = base_b + $signed({part_b[SB-1], part_b});
    assign new_a      = saturate(sum_a);
    assign new_b      = saturate(sum_b);

endmodule

// ----- hw/rtl/linear_interp_fractional_delay.sv -----
`timescale 1ns / 1ps
// top level of the linear-interpolated fractional delay line
// depends on lifd_pkg, lifd_ram, lifd_cfg, lifd_pos, lifd_alu
//
// usage
//   s_* channel takes one operation per transfer: s_tuser = opcode
//   (tick, tap read, tap add, tap set); s_tdata = sample_in, tap_whole,
//   tap_fraction from the lowest bit up.
//   m_* channel returns sample_out for ticks and tap reads; tap add and
//   tap set return nothing.
//   the apb port holds delay_whole (0x0), delay_fraction (0x4) and
//   reverse_taps (0x8); write it only while the line is idle.
//   the samples sit in two memory banks, even and odd cells, so both
//   neighbors of a position are read together and written together.
//   each operation passes a read state, where both banks are read, then
//   an update and write state; the next transfer is taken in that write
//   state unless the output stalls it, and the result is registered into
//   the output register as the write state ends. after reset the banks
//   are swept to zero row by row with s_tready low; configuration writes
//   are taken during the sweep. a stalled receiver holds the result in the
//   output register; tap add and tap set still go through, and a result-
//   producing operation waits in its write state until the register frees up.
module linear_interp_fractional_delay #(
    parameter int LINE_DEPTH    = lifd_pkg::LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS   = lifd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lifd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lifd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lifd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lifd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_in, tap_whole, tap_fraction
    input  logic [((SAMPLE_BITS + lifd_pkg::WHOLE_BITS + FRACTION_BITS + 7) / 8) * 8 - 1:0]
                                                s_tdata,
    // opcode
    input  logic [lifd_pkg::OPCODE_BITS-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_out
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int SB    = SAMPLE_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int WB    = lifd_pkg::WHOLE_BITS;
    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int RW    = AW - 1;
    localparam int OUT_W = ((SB + 7) / 8) * 8;
    localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};

    lifd_pkg::state_t state_reg;
    lifd_pkg::state_t state_next;

    lifd_pkg::op_t    op_reg;
    logic [SB-1:0]    samp_reg;
    logic [WB-1:0]    whole_reg;
    logic [FB-1:0]    frac_reg;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [RW-1:0]    clr_reg;
    logic [RW-1:0]    row0_reg;
    logic [RW-1:0]    row1_reg;
    logic             a_odd_reg;
    logic [SB-1:0]    pa_reg;
    logic [SB-1:0]    pb_reg;
    logic             out_valid_reg;
    logic [SB-1:0]    out_data_reg;

    logic [WB-1:0]    delay_whole;
    logic [FB-1:0]    delay_fraction;
    logic             reverse_taps;
    logic [WB-1:0]    pos_whole;
    logic [FB-1:0]    pos_fraction;

    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [RW-1:0]    row0;
    logic [RW-1:0]    row1;
    logic [FB:0]      weight_a;
    logic signed [SB+FB+1:0] prod_a;
    logic signed [SB+FB+1:0] prod_b;

    logic [SB-1:0]    rdata0;
    logic [SB-1:0]    rdata1;
    logic [SB-1:0]    cell_a;
    logic [SB-1:0]    cell_b;
    logic [SB-1:0]    interp;
    logic [SB-1:0]    new_a;
    logic [SB-1:0]    new_b;

    logic             has_result;
    logic             stall_out;
    logic             take;
    logic             write_go;
    logic             clr_run;
    logic             re;
    logic             we0;
    logic             we1;
    logic [RW-1:0]    wrow0;
    logic [RW-1:0]    wrow1;
    logic [SB-1:0]    wdata0;
    logic [SB-1:0]    wdata1;

    lifd_cfg #(
        .FRACTION_BITS(FB)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .delay_whole   (delay_whole),
        .delay_fraction(delay_fraction),
        .reverse_taps  (reverse_taps)
    );

    lifd_pos #(
        .FRACTION_BITS(FB)
    ) u_pos (
        .op            (lifd_pkg::op_t'(s_tuser)),
        .tap_whole     (s_tdata[SB+WB-1:SB]),
        .tap_fraction  (s_tdata[SB+WB+FB-1:SB+WB]),
        .delay_whole   (delay_whole),
        .delay_fraction(delay_fraction),
        .reverse_taps  (reverse_taps),
        .pos_whole     (pos_whole),
        .pos_fraction  (pos_fraction)
    );

    // read stage: neighbor cells, bank split by address parity
    assign addr_a = wp_reg + AW'(whole_reg) + AW'(1);
    assign addr_b = addr_a + AW'(1);
    assign row0   = addr_a[0] ? addr_b[AW-1:1] : addr_a[AW-1:1];
    assign row1   = addr_a[0] ? addr_a[AW-1:1] : addr_b[AW-1:1];

    // tap weights split the sample by (1 - f) and f
    assign weight_a = FRAC_ONE - {1'b0, frac_reg};
    assign prod_a   = $signed(samp_reg) * $signed({1'b0, weight_a});
    assign prod_b   = $signed(samp_reg) * $signed({2'b00, frac_reg});

    lifd_ram #(
        .WIDTH(SB),
        .DEPTH(LINE_DEPTH / 2)
    ) u_bank_even (
        .clk  (clk),
        .we   (we0),
        .waddr(wrow0),
        .wdata(wdata0),
        .re   (re),
        .raddr(row0),
        .rdata(rdata0)
    );

    lifd_ram #(
        .WIDTH(SB),
        .DEPTH(LINE_DEPTH / 2)
    ) u_bank_odd (
        .clk  (clk),
        .we   (we1),
        .waddr(wrow1),
        .wdata(wdata1),
        .re   (re),
        .raddr(row1),
        .rdata(rdata1)
    );

    assign cell_a = a_odd_reg ? rdata1 : rdata0;
    assign cell_b = a_odd_reg ? rdata0 : rdata1;

    lifd_alu #(
        .SAMPLE_BITS  (SB),
        .FRACTION_BITS(FB)
    ) u_alu (
        .op      (op_reg),
        .cell_a  (cell_a),
        .cell_b  (cell_b),
        .fraction(frac_reg),
        .part_a  (pa_reg),
        .part_b  (pb_reg),
        .interp  (interp),
        .new_a   (new_a),
        .new_b   (new_b)
    );

    assign has_result = (op_reg == lifd_pkg::OP_TICK) || (op_reg == lifd_pkg::OP_TAP_READ);
    assign stall_out  = has_result && out_valid_reg && !m_tready;
    assign take       = s_tvalid && s_tready;
    assign wp_next    = wp_reg - AW'(1);

    // control outputs
    always_comb
    begin
        s_tready = 1'b0;
        write_go = 1'b0;
        clr_run  = 1'b0;
        re       = 1'b0;
        we0      = 1'b0;
        we1      = 1'b0;
        wrow0    = row0_reg;
        wrow1    = row1_reg;
        wdata0   = a_odd_reg ? new_b : new_a;
        wdata1   = a_odd_reg ? new_a : new_b;
        unique case (state_reg)
            lifd_pkg::ST_CLEAR:
            begin
                clr_run = 1'b1;
                we0     = 1'b1;
                we1     = 1'b1;
                wrow0   = clr_reg;
                wrow1   = clr_reg;
                wdata0  = '0;
                wdata1  = '0;
            end
            lifd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            lifd_pkg::ST_READ:
            begin
                re = 1'b1;
            end
            lifd_pkg::ST_WRITE:
            begin
                if (!stall_out)
                begin
                    write_go = 1'b1;
                    s_tready = 1'b1;
                    unique case (op_reg)
                        lifd_pkg::OP_TICK:
                        begin
                            we0    = !wp_reg[0];
                            we1    = wp_reg[0];
                            wrow0  = wp_reg[AW-1:1];
                            wrow1  = wp_reg[AW-1:1];
                            wdata0 = samp_reg;
                            wdata1 = samp_reg;
                        end
                        lifd_pkg::OP_TAP_READ:
                        begin
                        end
                        lifd_pkg::OP_TAP_ADD, lifd_pkg::OP_TAP_SET:
                        begin
                            we0 = 1'b1;
                            we1 = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lifd_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = lifd_pkg::ST_IDLE;
                end
            end
            lifd_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = lifd_pkg::ST_READ;
                end
            end
            lifd_pkg::ST_READ:
            begin
                state_next = lifd_pkg::ST_WRITE;
            end
            lifd_pkg::ST_WRITE:
            begin
                if (write_go)
                begin
                    state_next = take ? lifd_pkg::ST_READ : lifd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lifd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lifd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_run)
            begin
                clr_reg <= clr_reg + RW'(1);
            end
            if (write_go && op_reg == lifd_pkg::OP_TICK)
            begin
                wp_reg <= wp_next;
            end
            if (write_go && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= lifd_pkg::op_t'(s_tuser);
            samp_reg  <= s_tdata[SB-1:0];
            whole_reg <= pos_whole;
            frac_reg  <= pos_fraction;
        end
        if (state_reg == lifd_pkg::ST_READ)
        begin
            row0_reg  <= row0;
            row1_reg  <= row1;
            a_odd_reg <= addr_a[0];
            pa_reg    <= prod_a[SB+FB-1:FB];
            pb_reg    <= prod_b[SB+FB-1:FB];
        end
        if (write_go && has_result)
        begin
            out_data_reg <= interp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

// ----- test/linear_interp_fractional_delay_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the linear-interpolated fractional delay line
// depends on lifd_pkg and linear_interp_fractional_delay; predicts every result
// from its own copy of the sample memory, write position and registers
module linear_interp_fractional_delay_test;

    localparam int    DEPTH          = lifd_pkg::LINE_DEPTH_DEF;
    localparam int    FRAC_BITS      = lifd_pkg::FRACTION_BITS_DEF;
    localparam int    WB             = lifd_pkg::WHOLE_BITS;
    localparam int    DB             = lifd_pkg::APB_DATA_BITS;
    localparam longint FRAC_ONE      = 64'sd1 << FRAC_BITS;
    localparam longint FRAC_MASK     = FRAC_ONE - 1;
    localparam longint SAMPLE_HI     = 32767;
    localparam longint SAMPLE_LO     = -32768;
    localparam int    SETTLE_CYCLES  = 8;
    localparam int    STALL_LIMIT    = 4000;
    localparam int    MAX_REPORTS    = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lifd_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [DB-1:0] pwdata = '0;
    logic [DB-1:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // sample_in, tap_whole, tap_fraction, zero fill
    logic [47:0] s_tdata = '0;
    // opcode
    logic [lifd_pkg::OPCODE_BITS-1:0] s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // sample_out
    logic [15:0] m_tdata;

    // predicted line state
    logic signed [15:0] line_mem [DEPTH];
    logic [WB-1:0] line_wpos;
    int          cfg_delay_whole;
    int          cfg_delay_frac;
    bit          cfg_reverse;
    logic signed [15:0] expected_samples [$];
    logic signed [15:0] wanted_sample;

    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    linear_interp_fractional_delay dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(string what);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    function automatic longint clip_sample(longint v);
        if (v > SAMPLE_HI)
            return SAMPLE_HI;
        if (v < SAMPLE_LO)
            return SAMPLE_LO;
        return v;
    endfunction

    // position in fixed point, whole part above FRAC_BITS
    function automatic longint mirror_position(longint pos);
        longint p;
        p = pos;
        if (cfg_reverse)
        begin
            p = (longint'(cfg_delay_whole) - 1) * FRAC_ONE - p;
            if (p < 0)
                p = 0;
        end
        return p;
    endfunction

    function automatic logic [WB-1:0] cell_index(longint whole, int offset);
        longint idx;
        idx = (longint'(line_wpos) + whole + longint'(offset)) % DEPTH;
        return idx[WB-1:0];
    endfunction

    function automatic logic signed [15:0] lerp_cells(longint whole, longint frac);
        longint a;
        longint b;
        longint r;
        a = longint'(line_mem[cell_index(whole, 1)]);
        b = longint'(line_mem[cell_index(whole, 2)]);
        r = a + (((b - a) * frac) >>> FRAC_BITS);
        return r[15:0];
    endfunction

    task automatic predict_line_op(lifd_pkg::op_t op, logic signed [15:0] sample,
                                   logic [WB-1:0] whole, logic [15:0] frac);
        longint pos;
        longint s;
        longint f;
        longint va;
        longint vb;
        logic [WB-1:0] ca;
        logic [WB-1:0] cb;
        s = longint'(sample);
        pos = longint'(whole) * FRAC_ONE + longint'(frac);
        case (op)
            lifd_pkg::OP_TICK:
            begin
                expected_samples.push_back(lerp_cells(longint'(cfg_delay_whole),
                                                      longint'(cfg_delay_frac)));
                line_mem[line_wpos] = sample;
                line_wpos = line_wpos - 1'b1;
            end
            lifd_pkg::OP_TAP_READ:
            begin
                if (pos >= longint'(cfg_delay_whole) * FRAC_ONE)
                    pos = longint'(cfg_delay_whole) * FRAC_ONE;
                pos = mirror_position(pos);
                expected_samples.push_back(lerp_cells(pos >>> FRAC_BITS, pos & FRAC_MASK));
            end
            default:
            begin
                pos = mirror_position(pos);
                f = pos & FRAC_MASK;
                ca = cell_index(pos >>> FRAC_BITS, 1);
                cb = cell_index(pos >>> FRAC_BITS, 2);
                va = (s * (FRAC_ONE - f)) >>> FRAC_BITS;
                vb = (s * f) >>> FRAC_BITS;
                if (op == lifd_pkg::OP_TAP_ADD)
                begin
                    va = va + longint'(line_mem[ca]);
                    vb = vb + longint'(line_mem[cb]);
                end
                va = clip_sample(va);
                vb = clip_sample(vb);
                line_mem[ca] = va[15:0];
                line_mem[cb] = vb[15:0];
            end
        endcase
    endtask

    // one operation transfer; entered and left on a rising edge
    task automatic send_line_op(lifd_pkg::op_t op, logic signed [15:0] sample,
                                logic [WB-1:0] whole, logic [15:0] frac);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, frac, whole, sample};
        do
            @(posedge clk);
        while (!s_tready);
        predict_line_op(op, sample, whole, frac);
    endtask

    task automatic wait_line_idle();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic [1:0] idx, bit wr, logic [DB-1:0] wdata,
                              output logic [DB-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= lifd_pkg::APB_ADDR_BITS'(idx) << lifd_pkg::REG_INDEX_LSB;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure_line(int whole, int frac, bit rev);
        logic [DB-1:0] rd;
        apb_access(lifd_pkg::REG_DELAY_WHOLE, 1'b1, DB'(whole), rd);
        cfg_delay_whole = whole;
        apb_access(lifd_pkg::REG_DELAY_FRACTION, 1'b1, DB'(frac), rd);
        cfg_delay_frac = frac;
        apb_access(lifd_pkg::REG_REVERSE_TAPS, 1'b1, DB'(rev), rd);
        cfg_reverse = rev;
        apb_access(lifd_pkg::REG_DELAY_WHOLE, 1'b0, '0, rd);
        if (rd[WB-1:0] !== cfg_delay_whole[WB-1:0])
            report_mismatch($sformatf("delay_whole reads %0d, wrote %0d", rd, whole));
        apb_access(lifd_pkg::REG_DELAY_FRACTION, 1'b0, '0, rd);
        if (rd[15:0] !== cfg_delay_frac[15:0])
            report_mismatch($sformatf("delay_fraction reads %h, wrote %h", rd, frac));
        apb_access(lifd_pkg::REG_REVERSE_TAPS, 1'b0, '0, rd);
        if (rd[0] !== cfg_reverse)
            report_mismatch($sformatf("reverse_taps reads %0d, wrote %0d", rd, rev));
    endtask

    task automatic test_directed();
        configure_line(2, 16'h8000, 1'b0);
        send_line_op(lifd_pkg::OP_TICK,     16'sh7FFF, 10'd0,    16'h0000);
        send_line_op(lifd_pkg::OP_TICK,     16'sh8000, 10'd0,    16'h0000);
        send_line_op(lifd_pkg::OP_TICK,     16'sh1234, 10'd1023, 16'hFFFF);
        send_line_op(lifd_pkg::OP_TICK,     -16'sd1,   10'd0,    16'h0000);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd0,    16'h0000);
        // at or past the main delay: clamped
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd1023, 16'hFFFF);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd2,    16'h0000);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd1,    16'h4000);
        // sums that saturate
        send_line_op(lifd_pkg::OP_TAP_ADD,  16'sh7FFF, 10'd0,    16'h0000);
        send_line_op(lifd_pkg::OP_TAP_ADD,  16'sh8000, 10'd1,    16'hFFFF);
        send_line_op(lifd_pkg::OP_TAP_ADD,  16'sh8000, 10'd1,    16'hFFFF);
        // tap add wraps around the line, no clamp
        send_line_op(lifd_pkg::OP_TAP_ADD,  16'sh7FFF, 10'd1023, 16'h8000);
        send_line_op(lifd_pkg::OP_TAP_SET,  16'sh8000, 10'd2,    16'h0001);
        send_line_op(lifd_pkg::OP_TAP_SET,  16'sh7FFF, 10'd0,    16'hFFFF);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd0,    16'h0000);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd1,    16'h8000);
        send_line_op(lifd_pkg::OP_TICK,     16'sh0000, 10'd0,    16'h0000);
        wait_line_idle();
        // reverse mirror, including positions mirrored below zero
        configure_line(3, 16'h0000, 1'b1);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd0,    16'h0000);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd5,    16'h1234);
        send_line_op(lifd_pkg::OP_TAP_ADD,  16'sh4000, 10'd1,    16'h8000);
        send_line_op(lifd_pkg::OP_TAP_SET,  16'sh8001, 10'd1000, 16'h7FFF);
        send_line_op(lifd_pkg::OP_TAP_READ, 16'sh0000, 10'd1,    16'h8000);
        send_line_op(lifd_pkg::OP_TICK,     16'sh5555, 10'd0,    16'h0000);
        wait_line_idle();
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        lifd_pkg::op_t op;
        logic signed [15:0] sample;
        logic [WB-1:0] whole;
        logic [15:0] frac;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                op = lifd_pkg::OP_TICK;
            else if (pick < 70)
                op = lifd_pkg::OP_TAP_READ;
            else if (pick < 85)
                op = lifd_pkg::OP_TAP_ADD;
            else
                op = lifd_pkg::OP_TAP_SET;
            case ($urandom_range(9))
                0: sample = 16'sh7FFF;
                1: sample = 16'sh8000;
                default: sample = 16'($urandom);
            endcase
            if ($urandom_range(1) == 0)
                whole = WB'($urandom_range(0, (cfg_delay_whole + 2 > 1023) ?
                                              1023 : cfg_delay_whole + 2));
            else
                whole = WB'($urandom);
            case ($urandom_range(9))
                0: frac = 16'h0000;
                1: frac = 16'hFFFF;
                default: frac = 16'($urandom);
            endcase
            send_line_op(op, sample, whole, frac);
        end
        wait_line_idle();
    endtask

    // result check and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("sample_out %h with nothing expected", m_tdata));
            else
            begin
                wanted_sample = expected_samples.pop_front();
                if (m_tdata !== wanted_sample)
                    report_mismatch($sformatf("sample_out %h, expected %h",
                                              m_tdata, wanted_sample));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            line_mem[i] = '0;
        line_wpos = '0;
        cfg_delay_whole = 0;
        cfg_delay_frac = 0;
        cfg_reverse = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        configure_line(5, 16'h0001, 1'b0);
        test_random_traffic(370, 0, 0);
        configure_line(1022, 16'hFFFF, 1'b1);
        test_random_traffic(370, 50, 0);
        configure_line(0, 16'h0000, 1'b1);
        test_random_traffic(370, 0, 50);
        configure_line($urandom_range(1, 40), $urandom_range(0, 65535), 1'b0);
        test_random_traffic(370, 11, 11);
        configure_line(10'h2AA, 16'h5555, 1'b1);
        test_random_traffic(60, 0, 0);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
